### rtl/crrp_pkg.sv
`default_nettype none

package crrp_pkg;

   localparam int BUFFER_BYTES_DEFAULT = 256;
   localparam int CSR_INDEX_WIDTH      = 2;
   localparam int CSR_DATA_WIDTH       = 32;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_RESPONSE_LENGTH = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_BOX_ID_OVERRIDE = 2'd1;

   localparam logic [7:0] RESPONSE_LENGTH_RESET = 8'h90;

   localparam logic [1:0] STATUS_ID_FOUND  = 2'd0;
   localparam logic [1:0] STATUS_ENCRYPTED = 2'd1;
   localparam logic [1:0] STATUS_NO_ID     = 2'd2;

   localparam int         ENCRYPT_POSITION = 7;
   localparam int         RECORD_START     = 9;
   localparam logic [7:0] ENCRYPT_LIMIT    = 8'h0F;
   localparam logic [7:0] IDENT_LIMIT      = 8'hF0;

   localparam logic [7:0] TYPE_NULL    = 8'h00;
   localparam logic [7:0] TYPE_SHORT   = 8'h01;
   localparam logic [7:0] TYPE_D1      = 8'hD1;
   localparam logic [7:0] TYPE_DF      = 8'hDF;
   localparam logic [7:0] TYPE_EF      = 8'hEF;
   localparam logic [7:0] TYPE_BOX_ID  = 8'hF3;
   localparam logic [7:0] TYPE_F6      = 8'hF6;
   localparam logic [7:0] TYPE_FA      = 8'hFA;
   localparam logic [7:0] TYPE_FC      = 8'hFC;
   localparam logic [7:0] TYPE_LEN_5E  = 8'h5E;
   localparam logic [7:0] TYPE_LEN_67  = 8'h67;
   localparam logic [7:0] TYPE_LEN_DE  = 8'hDE;
   localparam logic [7:0] TYPE_LEN_E2  = 8'hE2;
   localparam logic [7:0] TYPE_LEN_E9  = 8'hE9;
   localparam logic [7:0] TYPE_LEN_F8  = 8'hF8;
   localparam logic [7:0] TYPE_LEN_FD  = 8'hFD;

   localparam logic [2:0] CAPTURE_BYTES = 3'd4;

   typedef struct packed {
      logic [8:0]  bytes_to_skip;
      logic        awaiting_length;
      logic        identifier_seen;
      logic [2:0]  capture_count;
      logic [31:0] captured_id;
      logic        id_found;
      logic        encrypted;
      logic        unknown_flag;
   } parse_state_type;

   typedef struct packed {
      logic [8:0] skip;
      logic       awaiting;
      logic       identifier;
      logic       capture;
      logic       unknown;
   } type_decode_type;

   function automatic type_decode_type decode_type(input logic [7:0] t,
                                                   input logic id_seen);
      type_decode_type d;
      d = '0;
      if (!id_seen && t < IDENT_LIMIT) begin
         d.identifier = 1'b1;
         d.skip       = 9'd3;
      end else begin
         unique case (t)
            TYPE_NULL:  d.skip = 9'd0;
            TYPE_EF:    d.skip = 9'd2;
            TYPE_D1:    d.skip = 9'd3;
            TYPE_DF:    d.skip = 9'd4;
            TYPE_BOX_ID: begin
               d.skip    = 9'd4;
               d.capture = 1'b1;
            end
            TYPE_F6:    d.skip = 9'd5;
            TYPE_FC:    d.skip = 9'd13;
            TYPE_SHORT: d.skip = 9'd6;
            TYPE_FA:    d.skip = 9'd8;
            TYPE_LEN_5E, TYPE_LEN_67, TYPE_LEN_DE, TYPE_LEN_E2,
            TYPE_LEN_E9, TYPE_LEN_F8, TYPE_LEN_FD: d.awaiting = 1'b1;
            default: begin
               d.unknown  = 1'b1;
               d.awaiting = 1'b1;
            end
         endcase
      end
      return d;
   endfunction

endpackage

`default_nettype wire

### rtl/crrp_parse_step.sv
`default_nettype none

module crrp_parse_step
   import crrp_pkg::*;
#(
   parameter int BUFFER_BYTES = BUFFER_BYTES_DEFAULT,
   parameter int POS_WIDTH    = $clog2(BUFFER_BYTES + 1)
) (
   input  wire logic [POS_WIDTH-1:0] position,
   input  wire parse_state_type      state,
   input  wire logic [7:0]           data_byte,
   input  wire logic [7:0]           response_length,
   output logic [POS_WIDTH-1:0]      position_next,
   output parse_state_type           state_next
);

   localparam int CMP_WIDTH = (POS_WIDTH > 8) ? POS_WIDTH : 8;

   type_decode_type decode;
   logic [1:0]      lane;
   logic            in_buffer;
   logic            in_records;
   logic            below_limit;

   assign decode      = decode_type(data_byte, state.identifier_seen);
   assign lane        = 2'(state.capture_count - 3'd1);
   assign in_buffer   = position < POS_WIDTH'(BUFFER_BYTES);
   assign in_records  = position >= POS_WIDTH'(RECORD_START);
   assign below_limit = CMP_WIDTH'(position) < CMP_WIDTH'(response_length);

   always_comb begin
      state_next    = state;
      position_next = position;
      if (in_buffer) begin
         position_next = position + 1'b1;
         if (position == POS_WIDTH'(ENCRYPT_POSITION) && data_byte > ENCRYPT_LIMIT) begin
            state_next.encrypted = 1'b1;
         end
         if (state.capture_count != 3'd0) begin
            state_next.captured_id   = state.captured_id |
                                       (32'(data_byte) << {lane, 3'b000});
            state_next.capture_count = state.capture_count - 3'd1;
         end
         if (in_records) begin
            if (state.bytes_to_skip != 9'd0) begin
               state_next.bytes_to_skip = state.bytes_to_skip - 9'd1;
            end else if (state.awaiting_length) begin
               state_next.awaiting_length = 1'b0;
               state_next.bytes_to_skip   = {1'b0, data_byte};
            end else if (below_limit) begin
               state_next.bytes_to_skip = decode.skip;
               if (decode.identifier) begin
                  state_next.identifier_seen = 1'b1;
               end
               if (decode.awaiting) begin
                  state_next.awaiting_length = 1'b1;
               end
               if (decode.unknown) begin
                  state_next.unknown_flag = 1'b1;
               end
               if (decode.capture) begin
                  state_next.capture_count = CAPTURE_BYTES;
                  state_next.captured_id   = '0;
                  state_next.id_found      = 1'b1;
               end
            end
         end
      end
   end

endmodule

`default_nettype wire

### rtl/card_response_record_parser.sv
// Channel   Direction  Handshake            Payload
// req_      in         req_valid/req_stall  req_data_byte, req_last_byte
// rsp_      out        rsp_valid/rsp_stall  rsp_status, rsp_box_id, rsp_unknown_type_seen
// csr_      in         csr_write_enable     csr_index, csr_write_data
//
// One request byte is taken every cycle unless req_stall holds it off; the parse state is updated in the same cycle.
// A request with req_last_byte set shows its result on rsp_ in the cycle after it is taken.
// Reset is synchronous and clears the parse state; response_length returns to 144.
// Bytes that produce no result are taken even while a result waits under rsp_stall;
// a last byte is held off only while the result register is still full and stalled.
`default_nettype none

module card_response_record_parser
   import crrp_pkg::*;
#(
   parameter int BUFFER_BYTES = BUFFER_BYTES_DEFAULT
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_stall,
   input  wire logic [7:0]                 req_data_byte,
   input  wire logic                       req_last_byte,
   output logic                            rsp_valid,
   input  wire logic                       rsp_stall,
   output logic [1:0]                      rsp_status,
   output logic [31:0]                     rsp_box_id,
   output logic                            rsp_unknown_type_seen,
   input  wire logic                       csr_write_enable,
   input  wire logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [CSR_DATA_WIDTH-1:0]  csr_write_data
);

   localparam int POS_WIDTH = $clog2(BUFFER_BYTES + 1);

   logic [7:0]           response_length_ff;
   logic [31:0]          box_id_override_ff;
   logic [POS_WIDTH-1:0] position_ff;
   logic [POS_WIDTH-1:0] position_in;
   parse_state_type      state_ff;
   parse_state_type      state_in;
   logic                 rsp_valid_ff;
   logic [1:0]           rsp_status_ff;
   logic [1:0]           rsp_status_in;
   logic [31:0]          rsp_box_id_ff;
   logic [31:0]          rsp_box_id_in;
   logic                 rsp_unknown_ff;
   logic                 req_accept;
   logic                 finish;

   crrp_parse_step #(
      .BUFFER_BYTES (BUFFER_BYTES),
      .POS_WIDTH    (POS_WIDTH)
   ) u_step (
      .position        (position_ff),
      .state           (state_ff),
      .data_byte       (req_data_byte),
      .response_length (response_length_ff),
      .position_next   (position_in),
      .state_next      (state_in)
   );

   assign req_stall  = rsp_valid_ff && rsp_stall && req_last_byte;
   assign req_accept = req_valid && !req_stall;
   assign finish     = req_accept && req_last_byte;

   always_comb begin
      priority if (state_in.encrypted) begin
         rsp_status_in = STATUS_ENCRYPTED;
      end else if (state_in.id_found) begin
         rsp_status_in = STATUS_ID_FOUND;
      end else begin
         rsp_status_in = STATUS_NO_ID;
      end
      rsp_box_id_in = (box_id_override_ff != 32'd0) ? box_id_override_ff
                                                    : state_in.captured_id;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         response_length_ff <= RESPONSE_LENGTH_RESET;
         box_id_override_ff <= '0;
      end else if (csr_write_enable) begin
         if (csr_index == CSR_RESPONSE_LENGTH) begin
            response_length_ff <= csr_write_data[7:0];
         end else if (csr_index == CSR_BOX_ID_OVERRIDE) begin
            box_id_override_ff <= csr_write_data[31:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff <= '0;
         state_ff    <= '0;
      end else if (finish) begin
         // The end of a response returns the parser to its idle state.
         position_ff <= '0;
         state_ff    <= '0;
      end else if (req_accept) begin
         position_ff <= position_in;
         state_ff    <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (finish) begin
         rsp_status_ff  <= rsp_status_in;
         rsp_box_id_ff  <= rsp_box_id_in;
         rsp_unknown_ff <= state_in.unknown_flag;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_status            = rsp_status_ff;
   assign rsp_box_id            = rsp_box_id_ff;
   assign rsp_unknown_type_seen = rsp_unknown_ff;

`ifndef NO_ASSERTIONS
   a_position_bounded: assert property (@(posedge clock) disable iff (reset)
      position_ff <= POS_WIDTH'(BUFFER_BYTES))
      else $error("position ran past the buffer size");

   a_capture_bounded: assert property (@(posedge clock) disable iff (reset)
      state_ff.capture_count <= CAPTURE_BYTES)
      else $error("capture count out of range");

   a_capture_implies_found: assert property (@(posedge clock) disable iff (reset)
      state_ff.capture_count != 3'd0 |-> state_ff.id_found)
      else $error("capture running without a box record");

   a_finish_clears: assert property (@(posedge clock) disable iff (reset)
      finish |=> position_ff == '0 && state_ff == '0)
      else $error("parser not cleared after last byte");

   a_finish_result: assert property (@(posedge clock) disable iff (reset)
      finish |=> rsp_valid_ff)
      else $error("last byte did not produce a result");
`endif

endmodule

`default_nettype wire
